// ===== sv/rlrs_pkg.sv =====
// Package for the radio link recovery supervisor.
// Holds the event, operation, health and register index codes, plus the state,
// config and result structs. It has no dependencies.
package rlrs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_RESP   = 2'd1,
        MODE_POLL   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic {
        OP_STATUS = 1'b0,
        OP_ENABLE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        HEALTH_UNKNOWN = 2'd0,
        HEALTH_OK      = 2'd1,
        HEALTH_WARN    = 2'd2,
        HEALTH_RSVD    = 2'd3
    } health_t;

    localparam logic [2:0] RADIO_OFF   = 3'd0;
    localparam logic [2:0] RADIO_READY = 3'd1;

    localparam logic [1:0] RESULT_TARGET_ERR = 2'd1;

    localparam logic [2:0] CFG_DESIRED_ENABLED   = 3'd0;
    localparam logic [2:0] CFG_READY_POLL_PERIOD = 3'd1;
    localparam logic [2:0] CFG_BACKOFF_FIRST     = 3'd2;
    localparam logic [2:0] CFG_BACKOFF_SECOND    = 3'd3;
    localparam logic [2:0] CFG_BACKOFF_FINAL     = 3'd4;

    localparam logic [15:0] RESET_POLL_PERIOD    = 16'd10;
    localparam logic [15:0] RESET_BACKOFF_FIRST  = 16'd15;
    localparam logic [15:0] RESET_BACKOFF_SECOND = 16'd60;
    localparam logic [15:0] RESET_BACKOFF_FINAL  = 16'd450;

    localparam logic [7:0]  FAIL_MAX  = 8'hFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        desired_enabled;
        logic [15:0] ready_poll_period;
        logic [15:0] backoff_first;
        logic [15:0] backoff_second;
        logic [15:0] backoff_final;
    } cfg_t;

    typedef struct packed {
        logic        request_pending;
        op_t         pending_operation;
        logic        status_known;
        logic [2:0]  radio_state;
        logic [7:0]  radio_fault;
        logic [7:0]  failure_count;
        logic [15:0] retry_countdown;
        logic [15:0] ready_poll_count;
        logic [31:0] poll_command_count;
    } sup_state_t;

    typedef struct packed {
        op_t        resp_operation;
        logic [1:0] resp_result;
        logic [2:0] resp_radio_state;
        logic [7:0] resp_fault;
    } event_t;

    // packed from the lowest bit up: request_valid first
    typedef struct packed {
        logic [31:0] link_poll_count;
        logic [15:0] retry_ticks_left;
        logic [7:0]  recovery_failures;
        health_t     health;
        logic        command_busy;
        op_t         request_operation;
        logic        request_valid;
    } result_t;

endpackage

// ===== sv/rlrs_cfg.sv =====
// Configuration register bank of the recovery supervisor.
// Depends on rlrs_pkg for the register indexes and reset values.
module rlrs_cfg
    import rlrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_DESIRED_ENABLED:   cfg_next.desired_enabled   = cfg_wdata[0];
                CFG_READY_POLL_PERIOD: cfg_next.ready_poll_period = cfg_wdata;
                CFG_BACKOFF_FIRST:     cfg_next.backoff_first     = cfg_wdata;
                CFG_BACKOFF_SECOND:    cfg_next.backoff_second    = cfg_wdata;
                CFG_BACKOFF_FINAL:     cfg_next.backoff_final     = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.desired_enabled   <= 1'b1;
            cfg_reg.ready_poll_period <= RESET_POLL_PERIOD;
            cfg_reg.backoff_first     <= RESET_BACKOFF_FIRST;
            cfg_reg.backoff_second    <= RESET_BACKOFF_SECOND;
            cfg_reg.backoff_final     <= RESET_BACKOFF_FINAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/rlrs_step.sv =====
// Combinational event step of the recovery supervisor: next state and result.
// Depends on rlrs_pkg for codes and structs.
module rlrs_step
    import rlrs_pkg::*;
(
    input  cfg_t       cfg,
    input  sup_state_t cur,
    input  mode_t      mode,
    input  event_t     evt,
    output sup_state_t nxt,
    output result_t    res
);

    always_comb begin
        logic        iv;
        op_t         iop;
        logic        busy;
        logic        factual;
        logic [2:0]  eff_state;
        logic [7:0]  eff_fault;
        logic        idle;
        logic [7:0]  fc_inc;
        logic [15:0] rpc_inc;
        logic        do_backoff;

        nxt        = cur;
        iv         = 1'b0;
        iop        = OP_STATUS;
        busy       = 1'b0;
        do_backoff = 1'b0;
        factual    = (evt.resp_result <= RESULT_TARGET_ERR);
        eff_state  = factual ? evt.resp_radio_state : cur.radio_state;
        eff_fault  = factual ? evt.resp_fault : cur.radio_fault;
        idle       = (cur.failure_count == '0) && (cur.retry_countdown == '0);
        fc_inc     = (cur.failure_count == FAIL_MAX) ? FAIL_MAX : cur.failure_count + 8'd1;
        rpc_inc    = (cur.ready_poll_count == COUNT_MAX) ? COUNT_MAX
                                                         : cur.ready_poll_count + 16'd1;

        case (mode)
            MODE_TICK: begin
                if (!cur.request_pending) begin
                    if (cur.retry_countdown != '0) begin
                        nxt.retry_countdown = cur.retry_countdown - 16'd1;
                        if (cur.retry_countdown == 16'd1) begin
                            iv  = 1'b1;
                            iop = OP_ENABLE;
                        end
                    end else if (!cur.status_known) begin
                        iv  = 1'b1;
                        iop = OP_STATUS;
                    end else if (cfg.desired_enabled && cur.radio_state == RADIO_OFF) begin
                        iv  = 1'b1;
                        iop = OP_ENABLE;
                    end else if (cur.radio_state == RADIO_READY) begin
                        if (rpc_inc >= cfg.ready_poll_period) begin
                            nxt.ready_poll_count = '0;
                            iv  = 1'b1;
                            iop = OP_STATUS;
                        end else begin
                            nxt.ready_poll_count = rpc_inc;
                        end
                    end
                end
            end
            MODE_RESP: begin
                if (cur.request_pending && evt.resp_operation == cur.pending_operation) begin
                    nxt.request_pending = 1'b0;
                    if (factual) begin
                        nxt.status_known = 1'b1;
                        nxt.radio_state  = evt.resp_radio_state;
                        nxt.radio_fault  = evt.resp_fault;
                    end
                    if (cfg.desired_enabled) begin
                        if (factual && eff_state == RADIO_READY && eff_fault == '0) begin
                            nxt.failure_count    = '0;
                            nxt.retry_countdown  = '0;
                            nxt.ready_poll_count = '0;
                        end else if (evt.resp_operation == OP_STATUS) begin
                            if (factual && (eff_state == RADIO_OFF || eff_fault != '0)
                                    && idle) begin
                                iv  = 1'b1;
                                iop = OP_ENABLE;
                            end else if (!factual && idle) begin
                                do_backoff = 1'b1;
                            end
                        end else begin
                            do_backoff = 1'b1;
                        end
                    end
                end
            end
            MODE_POLL: begin
                if (cur.request_pending) begin
                    busy = 1'b1;
                end else begin
                    nxt.poll_command_count = cur.poll_command_count + 32'd1;
                    iv  = 1'b1;
                    iop = OP_STATUS;
                end
            end
            default: ;
        endcase

        if (do_backoff) begin
            nxt.failure_count    = fc_inc;
            nxt.ready_poll_count = '0;
            if (fc_inc == 8'd1) begin
                nxt.retry_countdown = cfg.backoff_first;
            end else if (fc_inc == 8'd2) begin
                nxt.retry_countdown = cfg.backoff_second;
            end else begin
                nxt.retry_countdown = cfg.backoff_final;
            end
        end

        if (iv) begin
            nxt.request_pending   = 1'b1;
            nxt.pending_operation = iop;
        end

        res.request_valid     = iv;
        res.request_operation = iop;
        res.command_busy      = busy;
        if (nxt.status_known && nxt.radio_state == RADIO_READY && nxt.radio_fault == '0) begin
            res.health = HEALTH_OK;
        end else if (nxt.status_known || nxt.failure_count != '0) begin
            res.health = HEALTH_WARN;
        end else begin
            res.health = HEALTH_UNKNOWN;
        end
        res.recovery_failures = nxt.failure_count;
        res.retry_ticks_left  = nxt.retry_countdown;
        res.link_poll_count   = nxt.poll_command_count;
    end

endmodule

// ===== sv/radio_link_recovery_supervisor.sv =====
// Radio link recovery supervisor top level: input register, state, result register.
// Depends on rlrs_pkg, rlrs_cfg and rlrs_step.
//
// Each input transaction (a tick, a driver response or a link poll command) yields
// exactly one result transaction, via the input register and the result register.
// One event is taken every cycle while the result side keeps up; the combinational
// state update in rlrs_step between the two registers sets the rate. The result
// register backs up into the input register, so a stall on m_tready holds s_tready
// low only once both are full. Write configuration only while no events are in flight.
module radio_link_recovery_supervisor
    import rlrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // resp_operation, resp_result, resp_radio_state,
                                   // resp_fault, zero fill
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // request_valid, request_operation, command_busy,
                                   // health, recovery_failures, retry_ticks_left,
                                   // link_poll_count, zero fill
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t       cfg;
    sup_state_t state_reg;
    sup_state_t state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       in_valid_reg;
    mode_t      in_mode_reg;
    event_t     in_evt_reg;
    logic       m_tvalid_reg;
    logic       advance;
    logic       s_accept;

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    rlrs_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rlrs_step u_step (
        .cfg  (cfg),
        .cur  (state_reg),
        .mode (in_mode_reg),
        .evt  (in_evt_reg),
        .nxt  (state_next),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_tvalid_reg <= 1'b1;
                state_reg    <= state_next;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= mode_t'(s_tuser);
            in_evt_reg  <= {op_t'(s_tdata[0]), s_tdata[2:1], s_tdata[5:3], s_tdata[13:6]};
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, res_reg};

endmodule
